@@ sv/svm_pkg.sv @@
// Shared package of the stack VM executor: opcodes, status codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package svm_pkg;

   localparam int MEM_WORDS_DEF  = 16384;
   localparam int CODE_WORDS_DEF = 65536;
   localparam int PTR_W          = 17;
   localparam int DATA_W         = 32;
   localparam int PC_W           = 16;
   localparam logic [PTR_W-1:0] STACK_TOP_RST = 17'h10000;

   localparam logic [5:0] OP_LEA  = 6'd0;
   localparam logic [5:0] OP_IMM  = 6'd1;
   localparam logic [5:0] OP_JMP  = 6'd2;
   localparam logic [5:0] OP_CALL = 6'd3;
   localparam logic [5:0] OP_JZ   = 6'd4;
   localparam logic [5:0] OP_JNZ  = 6'd5;
   localparam logic [5:0] OP_ENT  = 6'd6;
   localparam logic [5:0] OP_ADJ  = 6'd7;
   localparam logic [5:0] OP_LEV  = 6'd8;
   localparam logic [5:0] OP_LI   = 6'd9;
   localparam logic [5:0] OP_LC   = 6'd10;
   localparam logic [5:0] OP_SI   = 6'd11;
   localparam logic [5:0] OP_SC   = 6'd12;
   localparam logic [5:0] OP_PUSH = 6'd13;
   localparam logic [5:0] OP_OR   = 6'd14;
   localparam logic [5:0] OP_XOR  = 6'd15;
   localparam logic [5:0] OP_AND  = 6'd16;
   localparam logic [5:0] OP_EQ   = 6'd17;
   localparam logic [5:0] OP_NE   = 6'd18;
   localparam logic [5:0] OP_LT   = 6'd19;
   localparam logic [5:0] OP_GT   = 6'd20;
   localparam logic [5:0] OP_LE   = 6'd21;
   localparam logic [5:0] OP_GE   = 6'd22;
   localparam logic [5:0] OP_SHL  = 6'd23;
   localparam logic [5:0] OP_SHR  = 6'd24;
   localparam logic [5:0] OP_ADD  = 6'd25;
   localparam logic [5:0] OP_SUB  = 6'd26;
   localparam logic [5:0] OP_MUL  = 6'd27;
   localparam logic [5:0] OP_DIV  = 6'd28;
   localparam logic [5:0] OP_MOD  = 6'd29;
   localparam logic [5:0] OP_EXIT = 6'd37;

   typedef enum logic [2:0] {
      VM_RUN     = 3'd0,
      VM_EXITED  = 3'd1,
      VM_ILLEGAL = 3'd2,
      VM_DIVZERO = 3'd3,
      VM_FAULT   = 3'd4
   } vm_status_type;

   typedef struct packed {
      logic clr;
      logic load;
      logic rd1;
      logic rd2;
      logic cap2;
      logic div_go;
      logic wb;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic need_div;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

@@ sv/stack_vm_instruction_executor.sv @@
// Top level of the stack VM instruction executor: controller plus datapath.
// Depends on svm_pkg, svm_ctrl, svm_dpath (and svm_div below it).
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  req_kind, req_operand
//   rsp_      out         rsp_valid / rsp_stall  rsp_next_pc, rsp_acc_value,
//                                                rsp_status, rsp_exit_value
//   csr_      in          csr_wr_en              csr_wr_data (stack top)
//
// An instruction passes through accept, first memory read, second memory
// read, capture and write-back; the single data memory port sets this order.
// DIV and MOD add the divide start and wait states for the bit-serial divider
// (one quotient bit per cycle); jumps and LEV pass through them for the target
// reduction when CODE_WORDS is not a power of two.
// After reset the data memory is zeroed one word a cycle, with req_stall high
// until the sweep ends; csr writes are taken throughout.
// The result register frees the controller: write-back proceeds as soon as
// the previous transaction leaves, so rsp_stall only holds the final step.
`timescale 1ns / 1ps
`default_nettype none
module stack_vm_instruction_executor
   import svm_pkg::*;
#(
   parameter int MEM_WORDS  = MEM_WORDS_DEF,
   parameter int CODE_WORDS = CODE_WORDS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // instruction transactions
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [5:0]        req_kind,
   input  wire logic [DATA_W-1:0] req_operand,
   // result transactions
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [PC_W-1:0]        rsp_next_pc,
   output logic [DATA_W-1:0]      rsp_acc_value,
   output logic [2:0]             rsp_status,
   output logic [DATA_W-1:0]      rsp_exit_value,
   // stack top register
   input  wire logic              csr_wr_en,
   input  wire logic [PTR_W-1:0]  csr_wr_data
);
   cmd_type cmd;
   sts_type sts;

   // sequence the memory phases and divide wait
   svm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold machine state, memory and the result register
   svm_dpath #(
      .MEM_WORDS  (MEM_WORDS),
      .CODE_WORDS (CODE_WORDS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_kind),
      .req_operand    (req_operand),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_pc    (rsp_next_pc),
      .rsp_acc_value  (rsp_acc_value),
      .rsp_status     (rsp_status),
      .rsp_exit_value (rsp_exit_value)
   );
endmodule
`default_nettype wire

@@ sv/svm_div.sv @@
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on svm_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none
module svm_div
   import svm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] dividend,
   input  wire logic [DATA_W-1:0] divisor,
   output logic                   done,
   output logic [DATA_W-1:0]      quot,
   output logic [DATA_W-1:0]      rem
);
   localparam int CNT_W = $clog2(DATA_W + 1);

   logic [DATA_W-1:0] quot_ff, rem_ff, dvs_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff;
   logic [DATA_W:0]   shifted, diff;

   always_comb begin
      shifted = {rem_ff, quot_ff[DATA_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         run_ff <= 1'b1;
         cnt_ff <= CNT_W'(DATA_W);
      end else if (run_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (run_ff) begin
         // restore when the trial subtraction goes negative
         rem_ff  <= diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
         quot_ff <= {quot_ff[DATA_W-2:0], ~diff[DATA_W]};
      end
   end

   assign done = ~run_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;
endmodule
`default_nettype wire

@@ sv/svm_ctrl.sv @@
// Sequencer of the stack VM executor: memory clear, read phases, divide wait
// and write-back. Depends on svm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svm_ctrl
   import svm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_RD1   = 8'b0000_0100,
      S_RD2   = 8'b0000_1000,
      S_USE   = 8'b0001_0000,
      S_DGO   = 8'b0010_0000,
      S_DWAIT = 8'b0100_0000,
      S_WB    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = S_RD1;
         end
         S_RD1: begin
            cmd.rd1  = 1'b1;
            state_in = S_RD2;
         end
         S_RD2: begin
            cmd.rd2  = 1'b1;
            state_in = S_USE;
         end
         S_USE: begin
            cmd.cap2 = 1'b1;
            state_in = sts.need_div ? S_DGO : S_WB;
         end
         S_DGO: begin
            cmd.div_go = 1'b1;
            state_in   = S_DWAIT;
         end
         S_DWAIT: begin
            if (sts.div_done) state_in = S_WB;
         end
         S_WB: begin
            cmd.wb = 1'b1;
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   assign req_stall = (state_ff != S_IDLE);
endmodule
`default_nettype wire

@@ sv/svm_dpath.sv @@
// Datapath of the stack VM executor: machine registers, data memory, ALU,
// result register. Depends on svm_pkg and svm_div.
`timescale 1ns / 1ps
`default_nettype none
module svm_dpath
   import svm_pkg::*;
#(
   parameter int MEM_WORDS  = MEM_WORDS_DEF,
   parameter int CODE_WORDS = CODE_WORDS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   input  wire logic [5:0]        req_kind,
   input  wire logic [DATA_W-1:0] req_operand,
   input  wire logic              csr_wr_en,
   input  wire logic [PTR_W-1:0]  csr_wr_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [PC_W-1:0]        rsp_next_pc,
   output logic [DATA_W-1:0]      rsp_acc_value,
   output logic [2:0]             rsp_status,
   output logic [DATA_W-1:0]      rsp_exit_value
);
   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [31:0] MEM_BYTES = 32'(MEM_WORDS * 4);
   localparam logic [31:0] CODE_SIZE = 32'(CODE_WORDS);
   localparam bit CODE_POW2 = ((CODE_WORDS & (CODE_WORDS - 1)) == 0);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(CODE_WORDS));

   function automatic logic word_ok(input logic [31:0] a);
      return (a[1:0] == 2'b00) && (a <= MEM_BYTES - 32'd4);
   endfunction

   function automatic logic [AW-1:0] widx(input logic [31:0] a);
      return a[AW+1:2];
   endfunction

   // machine state
   logic [PC_W-1:0]   pc_ff;
   logic [PTR_W-1:0]  sp_ff, fp_ff;
   logic [DATA_W-1:0] acc_ff;
   logic              halted_ff;
   vm_status_type     code_ff;
   // per-transaction state
   logic [5:0]        op_ff;
   logic [DATA_W-1:0] opd_ff, w1_ff, w2_ff;
   logic [AW-1:0]     clr_ff;
   // memory
   logic [DATA_W-1:0] mem [MEM_WORDS];
   logic [DATA_W-1:0] mem_q;
   logic [AW-1:0]     mem_idx;
   logic              mem_we;
   logic [DATA_W-1:0] mem_wd;
   // result register
   logic              rsp_valid_ff;
   logic [PC_W-1:0]   rsp_pc_ff;
   logic [DATA_W-1:0] rsp_acc_ff, rsp_ex_ff;
   vm_status_type     rsp_st_ff;

   // pointers and program counter arithmetic
   logic [PTR_W-1:0]  sp_dec, sp_inc, fp_inc, opd_x4;
   logic [PC_W:0]     pc_s1, pc_s2;
   logic [PC_W-1:0]   pc1, pc2, opd_wrap, w2_wrap;

   always_comb begin
      opd_x4 = {opd_ff[PTR_W-3:0], 2'b00};
      sp_dec = sp_ff - PTR_W'(4);
      sp_inc = sp_ff + PTR_W'(4);
      fp_inc = fp_ff + PTR_W'(4);
      pc_s1  = {1'b0, pc_ff} + (PC_W+1)'(1);
      pc_s2  = {1'b0, pc_ff} + (PC_W+1)'(2);
      pc1    = (pc_s1 >= (PC_W+1)'(CODE_WORDS)) ?
               PC_W'(pc_s1 - (PC_W+1)'(CODE_WORDS)) : pc_s1[PC_W-1:0];
      pc2    = (pc_s2 >= (PC_W+1)'(CODE_WORDS)) ?
               PC_W'(pc_s2 - (PC_W+1)'(CODE_WORDS)) : pc_s2[PC_W-1:0];
   end

   // divider: signed divide/modulo on magnitudes
   logic              is_divop, is_jump;
   logic [DATA_W-1:0] ua, ub, dv_q, dv_r;
   logic              dv_done;
   // jump target reduction modulo CODE_WORDS: reciprocal estimate of the
   // quotient, back-multiply and subtract, then one conditional subtract
   logic [DATA_W-1:0] wsrc, wq_ff, wr_ff, wr_fix, wqc;
   logic [63:0]       wprod;
   logic              wbusy_ff;

   always_comb begin
      is_divop = (op_ff == OP_DIV) || (op_ff == OP_MOD);
      is_jump  = (op_ff == OP_JMP) || (op_ff == OP_CALL) || (op_ff == OP_JZ) ||
                 (op_ff == OP_JNZ) || (op_ff == OP_LEV);
      ua = w1_ff[31]  ? (32'd0 - w1_ff)  : w1_ff;
      ub = acc_ff[31] ? (32'd0 - acc_ff) : acc_ff;
      wsrc   = (op_ff == OP_LEV) ? w2_ff : opd_ff;
      wprod  = 64'(wsrc) * 64'(RECIP);
      wqc    = wq_ff * CODE_SIZE;
      wr_fix = (wr_ff >= CODE_SIZE) ? (wr_ff - CODE_SIZE) : wr_ff;
      if (CODE_POW2) begin
         opd_wrap = PC_W'(opd_ff & (CODE_SIZE - 32'd1));
         w2_wrap  = PC_W'(w2_ff & (CODE_SIZE - 32'd1));
      end else begin
         opd_wrap = PC_W'(wr_fix);
         w2_wrap  = PC_W'(wr_fix);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) wbusy_ff <= 1'b0;
      else       wbusy_ff <= cmd.div_go;
   end

   always_ff @(posedge clock) begin
      if (cmd.div_go) wq_ff <= wprod[63:32];
      if (wbusy_ff)   wr_ff <= wsrc - wqc;
   end

   svm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (ua),
      .divisor  (ub),
      .done     (dv_done),
      .quot     (dv_q),
      .rem      (dv_r)
   );

   // ALU: left operand popped from the stack, right operand is the accumulator
   logic [DATA_W-1:0] alu_y, prod, byte_w;
   logic              lt_ab, lt_ba, shamt_big;

   always_comb begin
      lt_ab     = $signed(w1_ff) < $signed(acc_ff);
      lt_ba     = $signed(acc_ff) < $signed(w1_ff);
      shamt_big = (acc_ff >= 32'd32);
      prod      = w1_ff * acc_ff;
      case (op_ff)
         OP_OR:  alu_y = w1_ff | acc_ff;
         OP_XOR: alu_y = w1_ff ^ acc_ff;
         OP_AND: alu_y = w1_ff & acc_ff;
         OP_EQ:  alu_y = {31'd0, w1_ff == acc_ff};
         OP_NE:  alu_y = {31'd0, w1_ff != acc_ff};
         OP_LT:  alu_y = {31'd0, lt_ab};
         OP_GT:  alu_y = {31'd0, lt_ba};
         OP_LE:  alu_y = {31'd0, ~lt_ba};
         OP_GE:  alu_y = {31'd0, ~lt_ab};
         OP_SHL: alu_y = shamt_big ? 32'd0 : (w1_ff << acc_ff[4:0]);
         OP_SHR: alu_y = shamt_big ? {32{w1_ff[31]}} :
                         32'($signed(w1_ff) >>> acc_ff[4:0]);
         OP_ADD: alu_y = w1_ff + acc_ff;
         OP_SUB: alu_y = w1_ff - acc_ff;
         OP_MUL: alu_y = prod;
         OP_DIV: alu_y = (w1_ff[31] ^ acc_ff[31]) ? (32'd0 - dv_q) : dv_q;
         OP_MOD: alu_y = w1_ff[31] ? (32'd0 - dv_r) : dv_r;
         default: alu_y = 32'd0;
      endcase
      byte_w = w1_ff >> {acc_ff[1:0], 3'b000};
   end

   // write-back decode
   vm_status_type     st;
   logic [DATA_W-1:0] ex, nacc, wr_data, sc_word;
   logic [PC_W-1:0]   npc;
   logic [PTR_W-1:0]  nsp, nfp;
   logic              wr_op;
   logic [AW-1:0]     wr_idx;

   always_comb begin
      st      = VM_RUN;
      ex      = '0;
      npc     = pc1;
      nsp     = sp_ff;
      nfp     = fp_ff;
      nacc    = acc_ff;
      wr_op   = 1'b0;
      wr_idx  = widx({15'd0, sp_dec});
      wr_data = acc_ff;
      sc_word = w2_ff;
      case (w1_ff[1:0])
         2'd0:    sc_word[7:0]   = acc_ff[7:0];
         2'd1:    sc_word[15:8]  = acc_ff[7:0];
         2'd2:    sc_word[23:16] = acc_ff[7:0];
         default: sc_word[31:24] = acc_ff[7:0];
      endcase
      case (op_ff)
         OP_LEA: begin
            nacc = {15'd0, fp_ff} + {opd_ff[29:0], 2'b00};
            npc  = pc2;
         end
         OP_IMM: begin
            nacc = opd_ff;
            npc  = pc2;
         end
         OP_JMP: npc = opd_wrap;
         OP_CALL: begin
            wr_data = {16'd0, pc2};
            if (!word_ok({15'd0, sp_dec})) st = VM_FAULT;
            else begin
               wr_op = 1'b1;
               nsp   = sp_dec;
               npc   = opd_wrap;
            end
         end
         OP_JZ:  npc = (acc_ff != '0) ? pc2 : opd_wrap;
         OP_JNZ: npc = (acc_ff != '0) ? opd_wrap : pc2;
         OP_ENT: begin
            wr_data = {15'd0, fp_ff};
            if (!word_ok({15'd0, sp_dec})) st = VM_FAULT;
            else begin
               wr_op = 1'b1;
               nfp   = sp_dec;
               nsp   = sp_dec - opd_x4;
               npc   = pc2;
            end
         end
         OP_ADJ: begin
            nsp = sp_ff + opd_x4;
            npc = pc2;
         end
         OP_LEV: begin
            if (!word_ok({15'd0, fp_ff}) || !word_ok({15'd0, fp_inc})) st = VM_FAULT;
            else begin
               nfp = w1_ff[PTR_W-1:0];
               npc = w2_wrap;
               nsp = fp_inc + PTR_W'(4);
            end
         end
         OP_LI: begin
            if (!word_ok(acc_ff)) st = VM_FAULT;
            else nacc = w1_ff;
         end
         OP_LC: begin
            if (acc_ff >= MEM_BYTES) st = VM_FAULT;
            else nacc = {{24{byte_w[7]}}, byte_w[7:0]};
         end
         OP_SI: begin
            wr_idx = widx(w1_ff);
            if (!word_ok({15'd0, sp_ff}) || !word_ok(w1_ff)) st = VM_FAULT;
            else begin
               wr_op = 1'b1;
               nsp   = sp_inc;
            end
         end
         OP_SC: begin
            wr_idx  = widx(w1_ff);
            wr_data = sc_word;
            if (!word_ok({15'd0, sp_ff}) || (w1_ff >= MEM_BYTES)) st = VM_FAULT;
            else begin
               wr_op = 1'b1;
               nacc  = {{24{acc_ff[7]}}, acc_ff[7:0]};
               nsp   = sp_inc;
            end
         end
         OP_PUSH: begin
            if (!word_ok({15'd0, sp_dec})) st = VM_FAULT;
            else begin
               wr_op = 1'b1;
               nsp   = sp_dec;
            end
         end
         OP_EXIT: begin
            if (!word_ok({15'd0, sp_ff})) st = VM_FAULT;
            else begin
               st = VM_EXITED;
               ex = w1_ff;
            end
         end
         default: begin
            if (!(op_ff inside {[OP_OR:OP_MOD]})) st = VM_ILLEGAL;
            else if (!word_ok({15'd0, sp_ff})) st = VM_FAULT;
            else if (is_divop && (acc_ff == '0)) st = VM_DIVZERO;
            else begin
               nacc = alu_y;
               nsp  = sp_inc;
            end
         end
      endcase
   end

   logic wb_fire, out_free;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign wb_fire  = cmd.wb & out_free;

   // memory port: clear sweep, first read, second read, write-back
   logic [31:0] rd1_addr, rd2_addr;
   always_comb begin
      if (halted_ff) rd1_addr = {15'd0, sp_ff};
      else begin
         case (op_ff)
            OP_LEV:  rd1_addr = {15'd0, fp_ff};
            OP_LI:   rd1_addr = acc_ff;
            OP_LC:   rd1_addr = acc_ff;
            default: rd1_addr = {15'd0, sp_ff};
         endcase
      end
      rd2_addr = (op_ff == OP_LEV) ? {15'd0, fp_inc} : mem_q;
      mem_we   = 1'b0;
      mem_wd   = wr_data;
      mem_idx  = wr_idx;
      if (cmd.clr) begin
         mem_we  = 1'b1;
         mem_wd  = '0;
         mem_idx = clr_ff;
      end else if (cmd.rd1) begin
         mem_idx = widx(rd1_addr);
      end else if (cmd.rd2) begin
         mem_idx = widx(rd2_addr);
      end else begin
         mem_we = wb_fire & ~halted_ff & (st == VM_RUN) & wr_op;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_idx] <= mem_wd;
      mem_q <= mem[mem_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr) clr_ff <= clr_ff + AW'(1);
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_kind;
         opd_ff <= req_operand;
      end
      if (cmd.rd2)  w1_ff <= mem_q;
      if (cmd.cap2) w2_ff <= mem_q;
   end

   // machine registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         sp_ff     <= STACK_TOP_RST;
         fp_ff     <= STACK_TOP_RST;
         acc_ff    <= '0;
         halted_ff <= 1'b0;
         code_ff   <= VM_RUN;
      end else begin
         if (wb_fire && !halted_ff) begin
            if (st != VM_RUN) begin
               halted_ff <= 1'b1;
               code_ff   <= st;
            end else begin
               pc_ff  <= npc;
               sp_ff  <= nsp;
               fp_ff  <= nfp;
               acc_ff <= nacc;
            end
         end
         if (csr_wr_en) begin
            sp_ff <= csr_wr_data;
            fp_ff <= csr_wr_data;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (wb_fire) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (wb_fire) begin
         if (halted_ff) begin
            rsp_pc_ff  <= pc_ff;
            rsp_acc_ff <= acc_ff;
            rsp_st_ff  <= code_ff;
            rsp_ex_ff  <= ((code_ff == VM_EXITED) && word_ok({15'd0, sp_ff})) ?
                          w1_ff : '0;
         end else if (st != VM_RUN) begin
            rsp_pc_ff  <= pc_ff;
            rsp_acc_ff <= acc_ff;
            rsp_st_ff  <= st;
            rsp_ex_ff  <= ex;
         end else begin
            rsp_pc_ff  <= npc;
            rsp_acc_ff <= nacc;
            rsp_st_ff  <= VM_RUN;
            rsp_ex_ff  <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_pc    = rsp_pc_ff;
   assign rsp_acc_value  = rsp_acc_ff;
   assign rsp_status     = rsp_st_ff;
   assign rsp_exit_value = rsp_ex_ff;

   always_comb begin
      sts.clr_last = (clr_ff == AW'(MEM_WORDS - 1));
      sts.need_div = ~halted_ff & (is_divop | (~CODE_POW2 & is_jump));
      sts.div_done = is_divop ? dv_done : ~wbusy_ff;
      sts.out_free = out_free;
   end
endmodule
`default_nettype wire

@@ tb/svm_result_checker.sv @@
// Result checker for the stack VM instruction executor: predicts each result
// from the accepted instructions and compares it with what the block returns.
// Depends on svm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svm_result_checker
   import svm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [5:0]        req_kind,
   input  wire logic [DATA_W-1:0] req_operand,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [PC_W-1:0]   rsp_next_pc,
   input  wire logic [DATA_W-1:0] rsp_acc_value,
   input  wire logic [2:0]        rsp_status,
   input  wire logic [DATA_W-1:0] rsp_exit_value,
   input  wire logic              csr_wr_en,
   input  wire logic [PTR_W-1:0]  csr_wr_data,
   input  wire logic              run_done,
   output int                     fail_count
);

   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic [DATA_W-1:0] acc;
      vm_status_type     status;
      logic [DATA_W-1:0] exit_value;
   } vm_result_type;

   localparam logic [31:0] MEM_BYTES = 32'(MEM_WORDS_DEF) * 32'd4;

   // machine state as the block should hold it
   logic [PTR_W-1:0]  stack_top, sp, fp;
   logic [PC_W-1:0]   pc;
   logic [DATA_W-1:0] acc;
   logic              halted;
   vm_status_type     halt_code;
   logic [DATA_W-1:0] data_mem [0:MEM_WORDS_DEF-1];

   vm_result_type expected_results[$];

   function automatic logic word_ok(input logic [31:0] a);
      return a[1:0] == 2'b00 && a <= MEM_BYTES - 32'd4;
   endfunction

   function automatic logic [31:0] alu_result(input logic [5:0] op, input logic [31:0] a,
                                              input logic [31:0] b, output logic div_zero);
      div_zero = 1'b0;
      case (op)
         OP_OR:  return a | b;
         OP_XOR: return a ^ b;
         OP_AND: return a & b;
         OP_EQ:  return 32'(a == b);
         OP_NE:  return 32'(a != b);
         OP_LT:  return 32'($signed(a) < $signed(b));
         OP_GT:  return 32'($signed(a) > $signed(b));
         OP_LE:  return 32'($signed(a) <= $signed(b));
         OP_GE:  return 32'($signed(a) >= $signed(b));
         OP_SHL: return (b >= 32) ? 32'd0 : a << b[4:0];
         OP_SHR: return (b >= 32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
         OP_ADD: return a + b;
         OP_SUB: return a - b;
         OP_MUL: return a * b;
         default: begin
            if (b == 0) begin
               div_zero = 1'b1;
               return 32'd0;
            end
            // most negative over -1 overflows: quotient wraps, remainder is 0
            if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
               return (op == OP_MOD) ? 32'd0 : a;
            return (op == OP_MOD) ? 32'($signed(a) % $signed(b))
                                  : 32'($signed(a) / $signed(b));
         end
      endcase
   endfunction

   // Execute one instruction on the predicted state and return its result.
   task automatic run_instruction(input logic [5:0] op, input logic [31:0] opd,
                                  output vm_result_type r);
      logic [PC_W-1:0]   npc, pc2;
      logic [PTR_W-1:0]  nsp, nfp, t;
      logic [DATA_W-1:0] nacc, a, ex;
      logic              dz;
      vm_status_type     st;
      npc  = pc + 16'd1;
      pc2  = pc + 16'd2;
      nsp  = sp;
      nfp  = fp;
      nacc = acc;
      ex   = '0;
      st   = VM_RUN;
      if (halted) begin
         // hold the stopped result; refresh the exit word from the stack
         r.next_pc    = pc;
         r.acc        = acc;
         r.status     = halt_code;
         r.exit_value = (halt_code == VM_EXITED && word_ok(32'(sp))) ? data_mem[sp >> 2] : '0;
         return;
      end
      case (op)
         OP_LEA: begin
            nacc = 32'(fp) + (opd << 2);
            npc  = pc2;
         end
         OP_IMM: begin
            nacc = opd;
            npc  = pc2;
         end
         OP_JMP: npc = opd[15:0];
         OP_CALL: begin
            t = sp - 17'd4;
            if (!word_ok(32'(t))) st = VM_FAULT;
            else begin
               data_mem[t >> 2] = 32'(pc2);
               nsp = t;
               npc = opd[15:0];
            end
         end
         OP_JZ:  npc = (acc != 0) ? pc2 : opd[15:0];
         OP_JNZ: npc = (acc != 0) ? opd[15:0] : pc2;
         OP_ENT: begin
            t = sp - 17'd4;
            if (!word_ok(32'(t))) st = VM_FAULT;
            else begin
               data_mem[t >> 2] = 32'(fp);
               nfp = t;
               nsp = t - {opd[14:0], 2'b00};
               npc = pc2;
            end
         end
         OP_ADJ: begin
            nsp = sp + {opd[14:0], 2'b00};
            npc = pc2;
         end
         OP_LEV: begin
            t = fp + 17'd4;
            if (!word_ok(32'(fp)) || !word_ok(32'(t))) st = VM_FAULT;
            else begin
               nfp = data_mem[fp >> 2][PTR_W-1:0];
               npc = data_mem[t >> 2][PC_W-1:0];
               nsp = t + 17'd4;
            end
         end
         OP_LI: begin
            if (!word_ok(acc)) st = VM_FAULT;
            else nacc = data_mem[acc >> 2];
         end
         OP_LC: begin
            if (acc >= MEM_BYTES) st = VM_FAULT;
            else begin
               a    = data_mem[acc >> 2] >> (acc[1:0] * 8);
               nacc = {{24{a[7]}}, a[7:0]};
            end
         end
         OP_SI, OP_SC: begin
            if (!word_ok(32'(sp))) st = VM_FAULT;
            else begin
               a = data_mem[sp >> 2];
               if (op == OP_SI && !word_ok(a)) st = VM_FAULT;
               else if (op == OP_SC && a >= MEM_BYTES) st = VM_FAULT;
               else if (op == OP_SI) begin
                  data_mem[a >> 2] = acc;
                  nsp = sp + 17'd4;
               end else begin
                  data_mem[a >> 2][a[1:0]*8 +: 8] = acc[7:0];
                  nacc = {{24{acc[7]}}, acc[7:0]};
                  nsp  = sp + 17'd4;
               end
            end
         end
         OP_PUSH: begin
            t = sp - 17'd4;
            if (!word_ok(32'(t))) st = VM_FAULT;
            else begin
               data_mem[t >> 2] = acc;
               nsp = t;
            end
         end
         OP_EXIT: begin
            if (!word_ok(32'(sp))) st = VM_FAULT;
            else begin
               ex = data_mem[sp >> 2];
               st = VM_EXITED;
            end
         end
         default: begin
            if (op < OP_OR || op > OP_MOD) st = VM_ILLEGAL;
            else if (!word_ok(32'(sp))) st = VM_FAULT;
            else begin
               nacc = alu_result(op, data_mem[sp >> 2], acc, dz);
               if (dz) st = VM_DIVZERO;
               nsp = sp + 17'd4;
            end
         end
      endcase
      if (st != VM_RUN) begin
         // stop: keep all state, remember why
         halted       = 1'b1;
         halt_code    = st;
         r.next_pc    = pc;
         r.acc        = acc;
         r.status     = st;
         r.exit_value = ex;
         return;
      end
      pc  = npc;
      sp  = nsp;
      fp  = nfp;
      acc = nacc;
      r.next_pc    = pc;
      r.acc        = acc;
      r.status     = VM_RUN;
      r.exit_value = '0;
   endtask

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      $display("%0t: mismatch in %s: expected %08h, got %08h", $time, what, want, got);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      vm_result_type r, e;
      if (reset) begin
         stack_top = STACK_TOP_RST;
         sp        = STACK_TOP_RST;
         fp        = STACK_TOP_RST;
         pc        = '0;
         acc       = '0;
         halted    = 1'b0;
         halt_code = VM_RUN;
         foreach (data_mem[i]) data_mem[i] = '0;
         expected_results.delete();
      end else begin
         // a stack top write reloads both pointers
         if (csr_wr_en) begin
            stack_top = csr_wr_data;
            sp        = csr_wr_data;
            fp        = csr_wr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result transaction with nothing expected", $time);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_next_pc !== e.next_pc) report("next_pc", 32'(e.next_pc), 32'(rsp_next_pc));
               if (rsp_acc_value !== e.acc) report("acc_value", e.acc, rsp_acc_value);
               if (rsp_status !== e.status) report("status", 32'(e.status), 32'(rsp_status));
               if (rsp_exit_value !== e.exit_value)
                  report("exit_value", e.exit_value, rsp_exit_value);
            end
         end
         if (req_valid && !req_stall) begin
            run_instruction(req_kind, req_operand, r);
            expected_results.push_back(r);
         end
      end
   end

   // nothing may stay pending once the stimulus has drained
   always @(posedge run_done) begin
      if (expected_results.size() != 0) begin
         $display("%0d results never arrived", expected_results.size());
         fail_count++;
      end
   end

endmodule
`default_nettype wire

@@ tb/stack_vm_instruction_executor_tb.sv @@
// Testbench top for the stack VM instruction executor: clock, reset, stimulus
// and verdict. Depends on svm_pkg, the executor RTL and svm_result_checker.
`timescale 1ns / 1ps
`default_nettype none
module stack_vm_instruction_executor_tb;
   import svm_pkg::*;

   // the idle limit lies well above the reset clearing sweep and a divide
   localparam int IDLE_LIMIT = 50000;
   localparam logic [31:0] MIN_INT = 32'h8000_0000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [5:0]        req_kind = OP_IMM;
   logic [DATA_W-1:0] req_operand = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [PC_W-1:0]   rsp_next_pc;
   logic [DATA_W-1:0] rsp_acc_value;
   logic [2:0]        rsp_status;
   logic [DATA_W-1:0] rsp_exit_value;
   logic              csr_wr_en = 1'b0;
   logic [PTR_W-1:0]  csr_wr_data = '0;
   logic              run_done = 1'b0;
   logic              quiet = 1'b0;
   int                fail_count;
   int                issued = 0;
   int                returned = 0;
   int                idle_cycles = 0;

   stack_vm_instruction_executor i_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_kind, .req_operand,
      .rsp_valid, .rsp_stall, .rsp_next_pc, .rsp_acc_value, .rsp_status, .rsp_exit_value,
      .csr_wr_en, .csr_wr_data
   );

   svm_result_checker i_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_kind, .req_operand,
      .rsp_valid, .rsp_stall, .rsp_next_pc, .rsp_acc_value, .rsp_status, .rsp_exit_value,
      .csr_wr_en, .csr_wr_data, .run_done, .fail_count
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the result side at random, except during the quiet stretch.
   always @(posedge clock) rsp_stall <= !quiet && ($urandom_range(99) < 22);

   // Count returned transactions and end the run if everything stops moving.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) returned++;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else idle_cycles++;
   end

   // Send one instruction transaction; hold it until the block takes it.
   task automatic issue(input logic [5:0] kind, input logic [31:0] operand);
      while (!quiet && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_operand <= operand;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      issued++;
   endtask

   // Drop valid and wait for every result to come back.
   task automatic drain;
      req_valid <= 1'b0;
      while (returned < issued) @(posedge clock);
   endtask

   task automatic write_stack_top(input logic [PTR_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [31:0] rand_word;
      // favor the edges of the word range
      case ($urandom_range(5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return MIN_INT;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'($urandom_range(40)) - 32'd8;
         default: return $urandom();
      endcase
   endfunction

   // Binary ALU operation: left operand from the stack, right in the accumulator.
   task automatic alu_op(input logic [5:0] op, input logic [31:0] lhs, input logic [31:0] rhs);
      issue(OP_IMM, lhs);
      issue(OP_PUSH, $urandom());
      issue(OP_IMM, rhs);
      issue(op, $urandom());
   endtask

   task automatic store(input logic [31:0] addr, input logic [31:0] value, input logic byte_wide);
      issue(OP_IMM, addr);
      issue(OP_PUSH, $urandom());
      issue(OP_IMM, value);
      issue(byte_wide ? OP_SC : OP_SI, $urandom());
   endtask

   task automatic load(input logic [31:0] addr, input logic byte_wide);
      issue(OP_IMM, addr);
      issue(byte_wide ? OP_LC : OP_LI, $urandom());
   endtask

   // A stack-neutral snippet. Stores go to the low scratch area, clear of the stack.
   task automatic random_snippet(input logic with_stack);
      logic [5:0]  op;
      logic [31:0] k;
      int          n;
      op = 6'(OP_OR + $urandom_range(OP_MOD - OP_OR));
      case ($urandom_range(with_stack ? 8 : 5))
         0: begin
            if ((op == OP_DIV || op == OP_MOD) ) alu_op(op, rand_word(), rand_word() | 32'd1 << $urandom_range(31));
            else alu_op(op, rand_word(), rand_word());
         end
         1: load({16'd0, 16'($urandom()) & 16'hFFFC}, 1'b0);
         2: load({16'd0, 16'($urandom())}, 1'b1);
         3: begin
            issue(OP_IMM, $urandom_range(1) ? 32'd0 : rand_word());
            issue($urandom_range(1) ? OP_JZ : OP_JNZ, $urandom());
         end
         4: begin
            k = $urandom();
            issue(OP_ADJ, k);
            issue(OP_ADJ, -k);
         end
         5: begin
            case ($urandom_range(2))
               0: issue(OP_LEA, $urandom());
               1: issue(OP_IMM, $urandom());
               default: issue(OP_JMP, $urandom());
            endcase
         end
         6: store(32'($urandom_range(2047)) & ~32'd3, $urandom(), 1'b0);
         7: store(32'($urandom_range(2047)), rand_word(), 1'b1);
         default: begin
            // call a frame: enter, touch a local, do some work, leave
            n = $urandom_range(6);
            issue(OP_CALL, $urandom());
            issue(OP_ENT, n);
            if (n > 0) begin
               k = -32'($urandom_range(1, n));
               issue(OP_LEA, k);
               issue(OP_PUSH, $urandom());
               issue(OP_IMM, $urandom());
               issue(OP_SI, $urandom());
               issue(OP_LEA, k);
               issue($urandom_range(1) ? OP_LI : OP_LC, $urandom());
            end
            if ($urandom_range(1)) alu_op(op, rand_word(), rand_word() | 32'd1);
            issue(OP_LEV, $urandom());
         end
      endcase
   endtask

   initial begin
      int stop_kind;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: overflow division, signs of the remainder, shift count
      // limits, byte store and load with sign fill, word range edges
      alu_op(OP_DIV, MIN_INT, 32'hFFFF_FFFF);
      alu_op(OP_MOD, -32'd7, 32'd2);
      alu_op(OP_SHL, 32'd1, 32'd32);
      alu_op(OP_SHR, MIN_INT, 32'hFFFF_FFFF);
      store(32'd3, 32'h0000_01FF, 1'b1);
      load(32'd3, 1'b1);
      load(32'd65532, 1'b0);
      issue(OP_IMM, 32'h7FFF_FFFF);

      // random at the reset stack top
      while (issued < 430) random_snippet(1'b1);

      // lowest stack top: room for a single word only
      write_stack_top(17'd4);
      while (issued < 490) random_snippet(1'b0);

      // random stack top, first with no idling on either side
      write_stack_top(17'($urandom_range(1024, 16384)) << 2);
      quiet = 1'b1;
      while (issued < 620) random_snippet(1'b1);
      quiet = 1'b0;
      write_stack_top(17'h10000);
      while (issued < 830) random_snippet(1'b1);

      // stop the machine one way, then check that the stopped result holds
      stop_kind = $urandom_range(3);
      case (stop_kind)
         0: begin
            issue(OP_IMM, $urandom());
            issue(OP_PUSH, $urandom());
            issue(OP_EXIT, $urandom());
         end
         1: issue($urandom_range(1) ? 6'($urandom_range(30, 36)) : 6'($urandom_range(38, 63)),
                  $urandom());
         2: alu_op($urandom_range(1) ? OP_DIV : OP_MOD, rand_word(), 32'd0);
         default: load(32'd65536 + 32'($urandom_range(3)), $urandom_range(1));
      endcase
      issue(6'd63, 32'hFFFF_FFFF);
      repeat (8) issue(6'($urandom()), $urandom());

      drain();
      repeat (80) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire
